>>> sv/nem_pkg.sv
// shared types and constants for the nonparabolic effective mass core
// no dependencies
package nem_pkg;

    localparam int T_DEN_W  = 29;
    localparam int T_Q_W    = 42;
    localparam int M_DEN_W  = 42;
    localparam int M_Q_W    = 33;
    localparam int MASS_W   = 24;
    localparam logic [MASS_W-1:0] MASS_MAX = '1;
    localparam logic [1:0] ADDR_ENERGY = 2'd0;

    typedef struct packed {
        logic                    vld;
        logic                    last;
        logic                    bad;
        logic                    sign;
        logic signed [23:0]      kane_f;
        logic [23:0]             ep_mag;
        logic [T_DEN_W-1:0]      den1;
        logic [T_DEN_W-1:0]      den2;
    } t_front;

endpackage

>>> sv/nem_front.sv
// front stages: kinetic energy, clamp, gap terms and divisor setup
// depends on nem_pkg
module nem_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_ce,
    input  logic                i_vld,
    input  logic signed [23:0]  i_energy,
    input  logic signed [23:0]  i_band_edge,
    input  logic signed [23:0]  i_gap,
    input  logic signed [23:0]  i_kane_f,
    input  logic signed [23:0]  i_matrix_element,
    input  logic signed [23:0]  i_spin_orbit,
    input  logic                i_last_in,
    output nem_pkg::t_front     o_front
);
    import nem_pkg::*;

    logic               r_a_vld, r_b_vld, r_c_vld, r_d_vld, r_e_vld;
    logic               r_a_last, r_b_last, r_c_last, r_d_last, r_e_last;
    logic signed [23:0] r_a_eg, r_b_eg;
    logic signed [23:0] r_a_eso, r_b_eso, r_c_eso;
    logic signed [23:0] r_a_ep, r_b_ep, r_c_ep, r_d_ep;
    logic signed [23:0] r_a_f, r_b_f, r_c_f, r_d_f, r_e_f;
    logic signed [25:0] r_a_e2, r_b_ec;
    logic signed [26:0] r_c_d1, r_d_d1;
    logic signed [27:0] r_d_d2;
    logic [T_DEN_W-1:0] r_d_m1, r_e_den1, r_e_den2;
    logic               r_e_bad, r_e_sign;
    logic [23:0]        r_e_mag;

    logic signed [25:0] n_a_e2, n_b_neg, n_b_ec;
    logic signed [26:0] n_c_d1;
    logic signed [27:0] n_d_d2;
    logic signed [28:0] n_d_m1;
    logic signed [29:0] n_e_m2;
    logic signed [24:0] n_e_ep;
    logic               n_e_bad;

    assign n_a_e2  = (26'(i_energy) - 26'(i_band_edge)) <<< 1;
    assign n_b_neg = -26'(r_a_eg);
    assign n_b_ec  = (r_a_e2 < n_b_neg) ? n_b_neg : r_a_e2;
    assign n_c_d1  = 27'(r_b_ec) + (27'(r_b_eg) <<< 1);
    assign n_d_d2  = 28'(r_c_d1) + (28'(r_c_eso) <<< 1);
    assign n_d_m1  = (29'(r_c_d1) <<< 1) + 29'(r_c_d1);
    assign n_e_m2  = (30'(r_d_d2) <<< 1) + 30'(r_d_d2);
    assign n_e_ep  = r_d_ep[23] ? -25'(r_d_ep) : 25'(r_d_ep);
    assign n_e_bad = (r_d_d1 <= 27'sd0) || (r_d_d2 <= 28'sd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
        end else if (i_ce) begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
            r_e_vld <= r_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_a_e2   <= n_a_e2;
            r_a_eg   <= i_gap;
            r_a_eso  <= i_spin_orbit;
            r_a_ep   <= i_matrix_element;
            r_a_f    <= i_kane_f;
            r_a_last <= i_last_in;

            r_b_ec   <= n_b_ec;
            r_b_eg   <= r_a_eg;
            r_b_eso  <= r_a_eso;
            r_b_ep   <= r_a_ep;
            r_b_f    <= r_a_f;
            r_b_last <= r_a_last;

            r_c_d1   <= n_c_d1;
            r_c_eso  <= r_b_eso;
            r_c_ep   <= r_b_ep;
            r_c_f    <= r_b_f;
            r_c_last <= r_b_last;

            r_d_d1   <= r_c_d1;
            r_d_d2   <= n_d_d2;
            r_d_m1   <= n_d_m1[T_DEN_W-1:0];
            r_d_ep   <= r_c_ep;
            r_d_f    <= r_c_f;
            r_d_last <= r_c_last;

            r_e_bad  <= n_e_bad;
            r_e_den1 <= n_e_bad ? T_DEN_W'(1) : r_d_m1;
            r_e_den2 <= n_e_bad ? T_DEN_W'(1) : n_e_m2[T_DEN_W-1:0];
            r_e_sign <= r_d_ep[23];
            r_e_mag  <= n_e_ep[23:0];
            r_e_f    <= r_d_f;
            r_e_last <= r_d_last;
        end
    end

    assign o_front.vld    = r_e_vld;
    assign o_front.last   = r_e_last;
    assign o_front.bad    = r_e_bad;
    assign o_front.sign   = r_e_sign;
    assign o_front.kane_f = r_e_f;
    assign o_front.ep_mag = r_e_mag;
    assign o_front.den1   = r_e_den1;
    assign o_front.den2   = r_e_den2;

endmodule

>>> sv/nem_div.sv
// pipelined restoring divider, one quotient bit per stage
// no dependencies; the top bits of i_num above Q_W must be below i_den
module nem_div #(
    parameter int DEN_W  = 29,
    parameter int Q_W    = 42,
    parameter int SIDE_W = 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_ce,
    input  logic                    i_vld,
    input  logic [DEN_W+Q_W-1:0]    i_num,
    input  logic [DEN_W-1:0]        i_den,
    input  logic [SIDE_W-1:0]       i_side,
    output logic                    o_vld,
    output logic [Q_W-1:0]          o_quo,
    output logic [SIDE_W-1:0]       o_side
);

    logic               r_vld  [Q_W];
    logic [DEN_W-1:0]   r_rem  [Q_W];
    logic [Q_W-1:0]     r_lq   [Q_W];
    logic [DEN_W-1:0]   r_den  [Q_W];
    logic [SIDE_W-1:0]  r_side [Q_W];

    genvar k;
    generate
        for (k = 0; k < Q_W; k++) begin : g_stage
            logic               s_vld;
            logic [DEN_W-1:0]   s_rem;
            logic [Q_W-1:0]     s_lq;
            logic [DEN_W-1:0]   s_den;
            logic [SIDE_W-1:0]  s_side;
            logic [DEN_W:0]     n_trial;
            logic [DEN_W:0]     n_diff;
            logic               n_ge;

            if (k == 0) begin : g_first
                assign s_vld  = i_vld;
                assign s_rem  = i_num[DEN_W+Q_W-1:Q_W];
                assign s_lq   = i_num[Q_W-1:0];
                assign s_den  = i_den;
                assign s_side = i_side;
            end else begin : g_next
                assign s_vld  = r_vld[k-1];
                assign s_rem  = r_rem[k-1];
                assign s_lq   = r_lq[k-1];
                assign s_den  = r_den[k-1];
                assign s_side = r_side[k-1];
            end

            assign n_trial = {s_rem, s_lq[Q_W-1]};
            assign n_diff  = n_trial - {1'b0, s_den};
            assign n_ge    = n_trial >= {1'b0, s_den};

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (i_ce) begin
                    r_vld[k] <= s_vld;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    r_rem[k]  <= n_ge ? n_diff[DEN_W-1:0] : n_trial[DEN_W-1:0];
                    r_lq[k]   <= {s_lq[Q_W-2:0], n_ge};
                    r_den[k]  <= s_den;
                    r_side[k] <= s_side;
                end
            end
        end
    endgenerate

    assign o_vld  = r_vld[Q_W-1];
    assign o_quo  = r_lq[Q_W-1];
    assign o_side = r_side[Q_W-1];

endmodule

>>> sv/nonparabolic_effective_mass_core.sv
// pipeline order from input transfer to result valid: front stages, gap-term divider,
// denominator stages, mass divider, output register
// throughput: one point per cycle; the whole pipeline holds while a result waits
// reset: synchronous active-low i_rst_n clears all valid bits and sets energy to 0
// depends on nem_pkg, nem_front, nem_div
module nonparabolic_effective_mass_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [1:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic signed [23:0]  i_band_edge,
    input  logic signed [23:0]  i_gap,
    input  logic signed [23:0]  i_kane_f,
    input  logic signed [23:0]  i_matrix_element,
    input  logic signed [23:0]  i_spin_orbit,
    input  logic                i_last_in,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [23:0]         o_mass,
    output logic                o_saturated,
    output logic                o_last_out
);
    import nem_pkg::*;

    localparam int DEN_W_SUM = T_DEN_W + T_Q_W;
    localparam int M_NUM_W   = M_DEN_W + M_Q_W;

    logic signed [23:0] r_energy;
    logic               ce;
    t_front             front;

    logic [DEN_W_SUM-1:0] num1, num2;

    logic               v1, v2, vm;
    logic [T_Q_W-1:0]   q1, q2;
    logic [25:0]        side1;
    logic               side2;
    logic [M_Q_W-1:0]   qm;
    logic [1:0]         sidem;

    logic               r_p1_vld, r_p2_vld, r_p3_vld;
    logic               r_p1_last, r_p2_last, r_p3_last;
    logic               r_p1_bad, r_p2_bad, r_p3_bad;
    logic signed [23:0] r_p1_f;
    logic signed [43:0] r_p1_t1, r_p1_t2, r_p2_den;
    logic [M_DEN_W-1:0] r_p3_den;
    logic [M_NUM_W-1:0] r_p3_num;
    logic               r_out_vld, r_out_sat, r_out_last;
    logic [MASS_W-1:0]  r_out_mass;

    logic signed [43:0] n_t1, n_t2, n_den;
    logic               n_ok, n_ovf;
    logic [42:0]        n_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_energy <= '0;
        end else if (psel && penable && pwrite) begin
            r_energy <= pwdata[23:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = 32'(r_energy);

    assign ce      = !r_out_vld || i_ready;
    assign o_ready = ce;

    nem_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ce             (ce),
        .i_vld            (i_valid),
        .i_energy         (r_energy),
        .i_band_edge      (i_band_edge),
        .i_gap            (i_gap),
        .i_kane_f         (i_kane_f),
        .i_matrix_element (i_matrix_element),
        .i_spin_orbit     (i_spin_orbit),
        .i_last_in        (i_last_in),
        .o_front          (front)
    );

    assign num1 = DEN_W_SUM'({front.ep_mag, 18'b0});
    assign num2 = DEN_W_SUM'({front.ep_mag, 17'b0});

    nem_div #(.DEN_W(T_DEN_W), .Q_W(T_Q_W), .SIDE_W(26)) u_div_t1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_vld   (front.vld),
        .i_num   (num1),
        .i_den   (front.den1),
        .i_side  ({front.last, front.sign, front.kane_f}),
        .o_vld   (v1),
        .o_quo   (q1),
        .o_side  (side1)
    );

    nem_div #(.DEN_W(T_DEN_W), .Q_W(T_Q_W), .SIDE_W(1)) u_div_t2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_vld   (front.vld),
        .i_num   (num2),
        .i_den   (front.den2),
        .i_side  (front.bad),
        .o_vld   (v2),
        .o_quo   (q2),
        .o_side  (side2)
    );

    assign n_t1 = side1[24] ? -44'(q1) : 44'(q1);
    assign n_t2 = side1[24] ? -44'(q2) : 44'(q2);
    assign n_den = (44'sd1 <<< 16) + (44'(r_p1_f) <<< 1) + r_p1_t1 + r_p1_t2;
    assign n_ok  = !r_p2_bad && (r_p2_den > 44'sd0);
    assign n_num = (43'd1 << 32) + 43'(r_p2_den[42:1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
            r_p3_vld <= 1'b0;
        end else if (ce) begin
            r_p1_vld <= v1 && v2;
            r_p2_vld <= r_p1_vld;
            r_p3_vld <= r_p2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_p1_t1   <= n_t1;
            r_p1_t2   <= n_t2;
            r_p1_f    <= side1[23:0];
            r_p1_bad  <= side2;
            r_p1_last <= side1[25];

            r_p2_den  <= n_den;
            r_p2_bad  <= r_p1_bad;
            r_p2_last <= r_p1_last;

            r_p3_den  <= n_ok ? r_p2_den[M_DEN_W-1:0] : M_DEN_W'(1);
            r_p3_num  <= n_ok ? M_NUM_W'(n_num) : '0;
            r_p3_bad  <= !n_ok;
            r_p3_last <= r_p2_last;
        end
    end

    nem_div #(.DEN_W(M_DEN_W), .Q_W(M_Q_W), .SIDE_W(2)) u_div_mass (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_vld   (r_p3_vld),
        .i_num   (r_p3_num),
        .i_den   (r_p3_den),
        .i_side  ({r_p3_last, r_p3_bad}),
        .o_vld   (vm),
        .o_quo   (qm),
        .o_side  (sidem)
    );

    assign n_ovf = qm[M_Q_W-1:MASS_W] != '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (ce) begin
            r_out_vld <= vm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_out_mass <= (sidem[0] || n_ovf) ? MASS_MAX : qm[MASS_W-1:0];
            r_out_sat  <= sidem[0] || n_ovf;
            r_out_last <= sidem[1];
        end
    end

    assign o_valid     = r_out_vld;
    assign o_mass      = r_out_mass;
    assign o_saturated = r_out_sat;
    assign o_last_out  = r_out_last;

endmodule
